// ===== rtl/rfcd_pkg.sv =====
// Shared constants, types and a helper function for the radiometer frame channel demux.
// It depends on nothing. Every module of the block imports it.
package rfcd_pkg;

	// Frame geometry.
	localparam int FRAME_BYTES       = 3375;
	localparam int SCANS_PER_LINE    = 30;
	localparam int SCAN_STRIDE_WORDS = 72;
	localparam int WORD_LIMIT        = (FRAME_BYTES * 8) / 12;

	// Word layout inside a scan block.
	localparam int WIDE_WORDS   = 36;
	localparam int NARROW_END   = 51;
	localparam int WIDE_PER_CH  = 6;
	localparam int NARROW_PER_CH = 3;
	localparam int NARROW_CH_BASE = 6;

	// Reset values of the configuration registers.
	localparam logic [2:0] BIT_OFFSET_RST   = 3'd5;
	localparam logic [7:0] HEADER_WORDS_RST = 8'd90;

	// Configuration register indexes.
	typedef enum logic {
		CFG_BIT_OFFSET   = 1'b0,
		CFG_HEADER_WORDS = 1'b1
	} cfg_idx_t;

	// One assembled 12-bit word from the unpacker.
	typedef struct packed {
		logic        valid;
		logic [11:0] word;
	} word_t;

	// One demultiplexed sample.
	typedef struct packed {
		logic        valid;
		logic [3:0]  channel;
		logic [15:0] line;
		logic [7:0]  pixel;
		logic [15:0] sample;
		logic        line_done;
	} result_t;

	// Reverse the bit order of a 12-bit word.
	function automatic logic [11:0] reverse12(input logic [11:0] v);
		logic [11:0] r;
		for (int b = 0; b < 12; b++) begin
			r[b] = v[11 - b];
		end
		return r;
	endfunction

endpackage

// ===== rtl/rfcd_unpack.sv =====
// Bit unpacker: inverts each byte, drops the leading frame bits and packs the rest
// MSB-first into 12-bit words. Depends on rfcd_pkg.
module rfcd_unpack
	import rfcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic [7:0] data_byte,
	input  logic       frame_start,
	input  logic [2:0] bit_offset,
	output word_t      word_out
);

	logic [11:0] acc_q;
	logic [3:0]  held_q;
	logic [2:0]  skipped_q;

	logic [11:0] acc_c;
	logic [3:0]  held_c;
	logic [2:0]  skipped_c;
	logic [7:0]  inv_byte;
	logic [2:0]  skip_k;
	logic [3:0]  keep_n;
	logic [19:0] joined;
	logic [4:0]  total;
	logic [4:0]  extra;
	logic [3:0]  held_n;

	// A new frame starts from cleared state before the byte is used.
	always_comb begin
		acc_c     = frame_start ? 12'd0 : acc_q;
		held_c    = frame_start ? 4'd0 : held_q;
		skipped_c = frame_start ? 3'd0 : skipped_q;
	end

	// Skip the leading bits, then append the kept bits and cut a word when 12 are held.
	always_comb begin
		inv_byte = ~data_byte;
		skip_k   = (bit_offset > skipped_c) ? (bit_offset - skipped_c) : 3'd0;
		keep_n   = 4'd8 - {1'b0, skip_k};
		joined   = ({8'd0, acc_c} << keep_n) | {12'd0, inv_byte & (8'hFF >> skip_k)};
		total    = {1'b0, held_c} + {1'b0, keep_n};
		extra    = total - 5'd12;
		word_out.valid = (total >= 5'd12);
		word_out.word  = joined[extra[2:0] +: 12];
		held_n   = word_out.valid ? extra[3:0] : total[3:0];
	end

	// Unpacker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			held_q    <= '0;
			skipped_q <= '0;
		end else if (step) begin
			acc_q     <= joined[11:0];
			held_q    <= held_n;
			skipped_q <= skipped_c + skip_k;
		end
	end

endmodule

// ===== rtl/rfcd_map.sv =====
// Word demultiplexer: counts words through header and scan blocks and maps each
// kept word to channel, line and pixel. Depends on rfcd_pkg.
module rfcd_map
	import rfcd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       step,
	input  logic       frame_start,
	input  logic [7:0] header_words,
	input  word_t      word_in,
	output result_t    rslt
);

	logic [11:0] word_index_q;
	logic [4:0]  scan_index_q;
	logic [6:0]  word_in_scan_q;
	logic [15:0] line_count_q;

	logic [11:0] idx_c;
	logic [4:0]  scan_c;
	logic [6:0]  wis_c;
	logic        in_body;
	logic        wis_wrap;
	logic [2:0]  q6;
	logic [2:0]  rem6;
	logic [3:0]  t3;
	logic [2:0]  q3;
	logic [1:0]  rem3;
	logic [7:0]  pix;
	logic [3:0]  chan;
	logic        mapped;
	logic        last;

	// Per-frame counters restart at a frame start.
	always_comb begin
		idx_c  = frame_start ? 12'd0 : word_index_q;
		scan_c = frame_start ? 5'd0 : scan_index_q;
		wis_c  = frame_start ? 7'd0 : word_in_scan_q;
	end

	// Decide whether the word lies inside a scan block of the frame body.
	always_comb begin
		in_body = word_in.valid
			&& (idx_c < 12'(WORD_LIMIT))
			&& (idx_c >= {4'd0, header_words})
			&& (scan_c < 5'(SCANS_PER_LINE));
		wis_wrap = (wis_c >= 7'(SCAN_STRIDE_WORDS - 1));
	end

	// Channel and pixel from the word's place in its scan block.
	always_comb begin
		q6 = '0;
		for (int i = 1; i < 6; i++) begin
			q6 = q6 + 3'(wis_c >= 7'(WIDE_PER_CH * i));
		end
		rem6 = 3'(wis_c - 7'(q6) * 7'(WIDE_PER_CH));
		t3   = 4'(wis_c - 7'(WIDE_WORDS));
		q3   = '0;
		for (int i = 1; i < 5; i++) begin
			q3 = q3 + 3'(t3 >= 4'(NARROW_PER_CH * i));
		end
		rem3 = 2'(t3 - 4'(q3) * 4'(NARROW_PER_CH));
		mapped = 1'b1;
		if (wis_c < 7'(WIDE_WORDS)) begin
			chan = {1'b0, q6};
			// Pixel order is reversed inside each group of three.
			pix  = 8'(scan_c) * 8'd6
				+ ((rem6 < 3'd3) ? 8'(3'd2 - rem6) : 8'(3'd5 - rem6 + 3'd3));
		end else if (wis_c < 7'(NARROW_END)) begin
			chan = 4'(NARROW_CH_BASE) + {1'b0, q3};
			pix  = 8'(scan_c) * 8'd3 + 8'(2'd2 - rem3);
		end else begin
			chan   = '0;
			pix    = '0;
			mapped = 1'b0;
		end
		last = (scan_c == 5'(SCANS_PER_LINE - 1)) && (wis_c == 7'(NARROW_END - 1));
	end

	// Result for the output register.
	always_comb begin
		rslt.valid     = in_body && mapped;
		rslt.channel   = chan;
		rslt.line      = line_count_q;
		rslt.pixel     = pix;
		rslt.sample    = {reverse12(word_in.word), 4'd0};
		rslt.line_done = last;
	end

	// Word, scan and line counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_index_q   <= '0;
			scan_index_q   <= '0;
			word_in_scan_q <= '0;
			line_count_q   <= '0;
		end else if (step) begin
			if (word_in.valid && (idx_c != 12'hFFF)) begin
				word_index_q <= idx_c + 12'd1;
			end else begin
				word_index_q <= idx_c;
			end
			if (in_body) begin
				word_in_scan_q <= wis_wrap ? 7'd0 : wis_c + 7'd1;
				scan_index_q   <= wis_wrap ? scan_c + 5'd1 : scan_c;
			end else begin
				word_in_scan_q <= wis_c;
				scan_index_q   <= scan_c;
			end
			if (rslt.valid && last) begin
				line_count_q <= line_count_q + 16'd1;
			end
		end
	end

	// Channels never exceed the narrow channel range.
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		rslt.valid |-> (rslt.channel <= 4'd10))
		else $error("channel out of range");

	// The last sample of a line always comes from the last narrow channel.
	a_last_chan: assert property (@(posedge clk) disable iff (!arst_n)
		(rslt.valid && rslt.line_done) |-> (rslt.channel == 4'd10))
		else $error("line end on wrong channel");

	// The line count only moves after a line-ending sample.
	a_line_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(step && rslt.valid && rslt.line_done) |=> $stable(line_count_q))
		else $error("line count moved without a line end");

endmodule

// ===== rtl/radiometer_frame_channel_demux_unit.sv =====
// Top level of the radiometer frame channel demux: configuration registers, input
// register and result register around rfcd_unpack and rfcd_map. Depends on rfcd_pkg.
//
//   group  direction  tdata                                      side band
//   s_*    in         [7:0] data_byte                            tuser: frame_start
//   m_*    out        [3:0] channel [19:4] line [27:20] pixel     tlast: line_done
//                     [43:28] sample, [47:44] zero
//   cfg_*  in         index 0 bit_offset, index 1 header_words   write only
//
// One byte is taken every cycle while the output is not stalled; a sample passes the input and result registers.
// The input register feeds the unpacker and word mapper combinationally into the result register.
// Reset clears all counters at once; there is no clearing pass.
// A stalled result holds the result register, and the input register waits behind it.
module radiometer_frame_channel_demux_unit
	import rfcd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tuser,   // [0] frame_start
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [47:0] m_tdata,   // channel, line, pixel, sample, zero fill
	output logic        m_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_wdata
);

	logic [2:0]  bit_offset_q;
	logic [7:0]  header_words_q;
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        fs_s1;
	logic        valid_s2;
	result_t     rslt_s2;
	logic        advance;
	word_t       word;
	result_t     rslt;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_offset_q   <= BIT_OFFSET_RST;
			header_words_q <= HEADER_WORDS_RST;
		end else if (cfg_we) begin
			case (cfg_idx_t'(cfg_index))
				CFG_BIT_OFFSET:   bit_offset_q   <= cfg_wdata[2:0];
				CFG_HEADER_WORDS: header_words_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// The held byte is processed whenever the result register has room.
	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
			fs_s1   <= s_tuser;
		end
	end

	rfcd_unpack u_unpack (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (advance),
		.data_byte   (byte_s1),
		.frame_start (fs_s1),
		.bit_offset  (bit_offset_q),
		.word_out    (word)
	);

	rfcd_map u_map (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (advance),
		.frame_start  (fs_s1),
		.header_words (header_words_q),
		.word_in      (word),
		.rslt         (rslt)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= rslt.valid;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rslt_s2 <= rslt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, rslt_s2.sample, rslt_s2.pixel, rslt_s2.line, rslt_s2.channel};
	assign m_tlast  = rslt_s2.line_done;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for radiometer_frame_channel_demux_unit: streams frame bytes,
// predicts every channel sample in step with the input and checks each output transaction.
// Depends on rfcd_pkg and the unit's RTL only.
module tb_top;
	import rfcd_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 1350;
	localparam int HOLD_CYCLES  = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT  = 10000;
	localparam int CYCLE_LIMIT  = 2000000;

	// One predicted channel sample.
	typedef struct {
		logic [3:0]  channel;
		logic [15:0] line;
		logic [7:0]  pixel;
		logic [15:0] sample;
		logic        line_done;
	} chan_sample_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;    // [7:0] data_byte
	logic        s_tuser;    // [0] frame_start
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;    // [3:0] channel, [19:4] line, [27:20] pixel, [43:28] sample
	logic        m_tlast;    // line_done
	logic        cfg_we;
	cfg_idx_t    cfg_index;
	logic [7:0]  cfg_wdata;

	// Predicted samples waiting for their output transaction.
	chan_sample_t pending_samples[$];
	int failures = 0;

	// Shadow copy of the configuration registers.
	logic [2:0] shadow_bit_offset   = BIT_OFFSET_RST;
	logic [7:0] shadow_header_words = HEADER_WORDS_RST;

	// Shadow copy of the unpacker and word mapper state.
	logic [11:0] fr_acc       = '0;
	logic [3:0]  fr_held      = '0;
	logic [2:0]  fr_skipped   = '0;
	logic [11:0] fr_word_idx  = '0;
	logic [4:0]  fr_scan      = '0;
	logic [6:0]  fr_word_in_scan = '0;
	logic [15:0] line_cnt     = '0;

	// Sender burst state.
	int  burst_left = 0;
	bit  offering = 1'b0;

	// Receiver control: the test bumps hold_requests, the receiver serves it.
	int hold_requests = 0;
	int holds_served = 0;
	int hold_left = 0;
	int rx_mode = 0;
	int rx_mode_left = 0;

	radiometer_frame_channel_demux_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run guard: a hung handshake ends the run as a failure.
	initial begin : watchdog
		int cycle_count;
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Test completed with failures");
		$finish;
	end

	function automatic logic [11:0] mirror12(input logic [11:0] v);
		logic [11:0] r;
		for (int i = 0; i < 12; i++) begin
			r[i] = v[11 - i];
		end
		return r;
	endfunction

	// Per-frame state is cleared on a frame start; the line count survives.
	task automatic clear_frame_state();
		fr_acc = '0;
		fr_held = '0;
		fr_skipped = '0;
		fr_word_idx = '0;
		fr_scan = '0;
		fr_word_in_scan = '0;
	endtask

	// Advance the shadow state by one accepted byte and queue the sample it yields.
	task automatic predict_byte(input logic [7:0] raw, input logic frame_start);
		logic [7:0]   bits;
		logic         got_word;
		logic [11:0]  word;
		logic [11:0]  idx;
		int           s;
		int           w;
		int           chan;
		int           pix;
		chan_sample_t rec;
		bits = ~raw;
		got_word = 1'b0;
		word = '0;
		if (frame_start)
			clear_frame_state();
		for (int b = 7; b >= 0; b--) begin
			if (fr_skipped < shadow_bit_offset) begin
				fr_skipped++;
			end else begin
				fr_acc = {fr_acc[10:0], bits[b]};
				fr_held++;
				if (fr_held == 4'd12) begin
					fr_held = '0;
					got_word = 1'b1;
					word = fr_acc;
				end
			end
		end
		if (got_word) begin
			idx = fr_word_idx;
			// The word counter sticks at its top value.
			if (fr_word_idx != 12'hFFF)
				fr_word_idx++;
			if (idx < WORD_LIMIT && idx >= shadow_header_words && fr_scan < SCANS_PER_LINE) begin
				s = fr_scan;
				w = fr_word_in_scan;
				if (fr_word_in_scan == SCAN_STRIDE_WORDS - 1) begin
					fr_word_in_scan = '0;
					fr_scan++;
				end else begin
					fr_word_in_scan++;
				end
				// Only the first words of a scan block carry channel data.
				if (w < NARROW_END) begin
					if (w < WIDE_WORDS) begin
						chan = w / WIDE_PER_CH;
						pix = s * WIDE_PER_CH
							+ ((w % WIDE_PER_CH) / NARROW_PER_CH) * NARROW_PER_CH
							+ NARROW_PER_CH - 1 - (w % NARROW_PER_CH);
					end else begin
						chan = NARROW_CH_BASE + (w - WIDE_WORDS) / NARROW_PER_CH;
						pix = s * NARROW_PER_CH + NARROW_PER_CH - 1
							- ((w - WIDE_WORDS) % NARROW_PER_CH);
					end
					rec.channel = 4'(chan);
					rec.line = line_cnt;
					rec.pixel = 8'(pix);
					rec.sample = {mirror12(word), 4'h0};
					rec.line_done = (s == SCANS_PER_LINE - 1) && (w == NARROW_END - 1);
					pending_samples.insert(pending_samples.size(), rec);
					if (rec.line_done)
						line_cnt++;
				end
			end
		end
	endtask

	// Offer one byte; the valid stays high across a burst and drops between bursts.
	task automatic push_byte(input logic [7:0] data_byte, input logic frame_start);
		if (!offering && burst_left == 0) begin
			repeat ($urandom_range(0, 7) == 0 ? $urandom_range(10, 30) : $urandom_range(1, 5))
				@(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(100, 400)
				: $urandom_range(1, 16);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data_byte;
		s_tuser <= frame_start;
		offering = 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		predict_byte(data_byte, frame_start);
		burst_left--;
		if (burst_left <= 0) begin
			burst_left = 0;
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
	endtask

	// Stop offering, wait for every predicted sample, then let the pipeline settle.
	task automatic drain_block();
		int waited;
		waited = 0;
		if (offering) begin
			s_tvalid <= 1'b0;
			offering = 1'b0;
		end
		while (pending_samples.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		if (pending_samples.size() != 0) begin
			$display("%0t: %0d expected samples never arrived", $time, pending_samples.size());
			failures++;
			pending_samples.delete();
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One register write; the enable is low again before the next write can start.
	task automatic write_reg(input cfg_idx_t idx, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_BIT_OFFSET:   shadow_bit_offset = value[2:0];
			CFG_HEADER_WORDS: shadow_header_words = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_frame(input int nbytes, input logic with_start);
		for (int i = 0; i < nbytes; i++) begin
			push_byte(8'($urandom_range(0, 255)), with_start && i == 0);
		end
	endtask

	// Bytes straight after reset, without a frame start, under the reset register values.
	task automatic test_frame_from_reset();
		send_frame(200, 1'b0);
		drain_block();
	endtask

	// Extreme byte patterns, truncated frames and back-to-back frame starts.
	task automatic test_directed_patterns();
		logic [7:0] pattern[9];
		pattern = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h0F, 8'hF0, 8'h81, 8'h7E, 8'h01};
		write_reg(CFG_BIT_OFFSET, 8'd0);
		write_reg(CFG_HEADER_WORDS, 8'd0);
		for (int i = 0; i < 9; i++) begin
			push_byte(pattern[i], i == 0);
		end
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'h00, 1'b1);
		push_byte(8'hFF, 1'b1);
		drain_block();
		write_reg(CFG_BIT_OFFSET, 8'd7);
		push_byte(8'hFF, 1'b1);
		push_byte(8'h00, 1'b0);
		push_byte(8'hFF, 1'b0);
		push_byte(8'h80, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(8'h3C, 1'b0);
		drain_block();
	endtask

	// Register changes inside a frame: a raised offset skips more bits, a lowered one none.
	task automatic test_mid_frame_config();
		write_reg(CFG_BIT_OFFSET, 8'd2);
		write_reg(CFG_HEADER_WORDS, 8'd1);
		push_byte(8'hC3, 1'b1);
		drain_block();
		write_reg(CFG_BIT_OFFSET, 8'd6);
		send_frame(6, 1'b0);
		drain_block();
		write_reg(CFG_BIT_OFFSET, 8'd0);
		write_reg(CFG_HEADER_WORDS, 8'd3);
		send_frame(6, 1'b0);
		drain_block();
	endtask

	// Two whole frames to the end of the last scan block; the line count advances twice.
	// A long receiver hold-off in the middle backs the stream up to the input.
	task automatic test_full_lines();
		write_reg(CFG_BIT_OFFSET, 8'd0);
		write_reg(CFG_HEADER_WORDS, 8'd0);
		send_frame(500, 1'b1);
		hold_requests++;
		send_frame(FRAME_BYTES - 500, 1'b0);
		drain_block();
		write_reg(CFG_BIT_OFFSET, 8'(BIT_OFFSET_RST));
		write_reg(CFG_HEADER_WORDS, HEADER_WORDS_RST);
		send_frame(FRAME_BYTES, 1'b1);
		drain_block();
	endtask

	// A frame far past the word limit, long enough for the word counter to stick at its top.
	task automatic test_overlong_frame();
		write_reg(CFG_BIT_OFFSET, 8'd7);
		write_reg(CFG_HEADER_WORDS, 8'd255);
		send_frame(6200, 1'b1);
		drain_block();
	endtask

	// Groups of short frames with random content between register changes, with the
	// odd stray frame start, a frame that continues the previous one and some hold-offs.
	task automatic test_random_frames();
		int         sent;
		int         frames;
		int         len;
		logic [7:0] offs;
		logic [7:0] hdr;
		logic       fs;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			drain_block();
			case ($urandom_range(0, 3))
				0: offs = 8'd0;
				1: offs = 8'd7;
				default: offs = 8'($urandom_range(0, 7));
			endcase
			case ($urandom_range(0, 9))
				0: hdr = 8'd255;
				1, 2: hdr = 8'd0;
				default: hdr = 8'($urandom_range(0, 24));
			endcase
			write_reg(CFG_BIT_OFFSET, offs);
			if ($urandom_range(0, 2) != 0)
				write_reg(CFG_HEADER_WORDS, hdr);
			if ($urandom_range(0, 5) == 0)
				hold_requests++;
			frames = $urandom_range(2, 6);
			for (int f = 0; f < frames; f++) begin
				len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : $urandom_range(60, 140);
				for (int i = 0; i < len; i++) begin
					if (i == 0)
						fs = ($urandom_range(0, 9) != 0);
					else
						fs = ($urandom_range(0, 199) == 0);
					push_byte(8'($urandom_range(0, 255)), fs);
				end
				sent += len;
			end
		end
		drain_block();
	endtask

	// Receiver: long hold-offs on request, otherwise a stall pattern that changes mode.
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (hold_requests != holds_served) begin
			holds_served = hold_requests;
			hold_left = HOLD_CYCLES - 1;
			m_tready <= 1'b0;
		end else begin
			if (rx_mode_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_mode_left = $urandom_range(32, 256);
			end else begin
				rx_mode_left--;
			end
			case (rx_mode)
				0: m_tready <= 1'b1;
				1: m_tready <= 1'($urandom_range(0, 1));
				2: m_tready <= ($urandom_range(0, 7) != 0);
				default: m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, what, want, got);
			failures++;
		end
	endtask

	// Compare each output transaction with the oldest predicted sample.
	always @(posedge clk) begin : sample_check
		chan_sample_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_samples.size() == 0) begin
				$display("%0t: unexpected sample: expected none, actual tdata=%h tlast=%b",
					$time, m_tdata, m_tlast);
				failures++;
			end else begin
				want = pending_samples.pop_front();
				check_field("channel", want.channel, m_tdata[3:0]);
				check_field("line", want.line, m_tdata[19:4]);
				check_field("pixel", want.pixel, m_tdata[27:20]);
				check_field("sample", want.sample, m_tdata[43:28]);
				check_field("zero fill", 0, m_tdata[47:44]);
				check_field("line_done", want.line_done, m_tlast);
			end
		end
	end

	// Reset once, then the tests in turn.
	initial begin
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_BIT_OFFSET;
		cfg_wdata <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_frame_from_reset();
		test_directed_patterns();
		test_mid_frame_config();
		test_full_lines();
		test_overlong_frame();
		test_random_frames();
		drain_block();
		if (failures == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
